// ===== sv/cei_pkg.sv =====
// Package for the capacitor energy indicator.
// Holds shared constants, register index codes, ALU op codes and the config struct.
// No dependencies.
`default_nettype none

package cei_pkg;

    // Blink timing and LED count
    localparam int BLINK_PERIOD   = 100;
    localparam int BLINK_ON_TICKS = 50;
    localparam int LED_COUNT      = 6;
    localparam int BLINK_W        = $clog2(BLINK_PERIOD);

    // Field widths
    localparam int VOLT_W  = 15;
    localparam int SEL_W   = 6;
    localparam int DIV_W   = 8;
    localparam int COLOR_W = 24;
    localparam int SQ_W    = 2 * VOLT_W;
    localparam int CMP_W   = SQ_W + 6;
    localparam int CFG_IDX_W = 3;

    // LEDs that exist on the strip
    localparam logic [SEL_W-1:0] LED_MASK =
        (LED_COUNT >= SEL_W) ? {SEL_W{1'b1}} : SEL_W'((1 << LED_COUNT) - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VOLTAGE = 3'd0,
        CFG_HIGH_THRESH = 3'd1,
        CFG_LOW_THRESH  = 3'd2,
        CFG_LED_SELECT  = 3'd3,
        CFG_DIM_DIVISOR = 3'd4
    } t_cfg_idx;

    // Shared unit operations
    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [VOLT_W-1:0] max_voltage;
        logic [VOLT_W-1:0] high_threshold;
        logic [VOLT_W-1:0] low_threshold;
        logic [SEL_W-1:0]  led_select;
        logic [DIV_W-1:0]  dim_divisor;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/capacitor_energy_indicator.sv =====
// Capacitor energy indicator: top level with the sequencer around the shared unit.
// Depends on cei_pkg, cei_cfg and cei_alu.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one voltage sample in mV per
//   transaction. Output channel (o_out_valid / i_out_ready) gives the GRB colour,
//   the LED mask, the charging flag and the low-energy flag.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_wdata);
//   the user must write it only while the block is idle; the block does not check.
//   After acceptance a sample goes through three multiplies in the shared
//   unit, a compare setup state, eight restoring divide steps for
//   255 / dim_divisor and a finishing state. The block takes no new sample
//   until it is back in idle after the finishing state.
//   With thresholds out of order (max < high or high < low) a sample is
//   consumed while idle and gives no result and no state change.
//   Results sit in an output register; a new sample is accepted while it waits,
//   and the finishing cycle holds until that register is free.
//   Synchronous reset loads register defaults, clears charging and blink state.
`default_nettype none

module capacitor_energy_indicator
    import cei_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VOLT_W-1:0]    i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [VOLT_W-1:0]    i_voltage_sample,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [COLOR_W-1:0]        o_colour_grb,
    output logic [SEL_W-1:0]          o_led_mask,
    output logic                      o_charging,
    output logic                      o_low_energy
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_V, S_MUL_L, S_MUL_M, S_CMP, S_DIV, S_FINISH
    } t_state;

    t_cfg                     cfg;
    t_alu_op                  alu_op;
    logic [VOLT_W-1:0]        alu_a;
    logic [VOLT_W-1:0]        alu_b;
    logic [SQ_W-1:0]          alu_y;

    t_state                   r_state;
    logic [VOLT_W-1:0]        r_v;
    logic [SQ_W-1:0]          r_sq_v;
    logic [SQ_W-1:0]          r_sq_l;
    logic [SQ_W-1:0]          r_sq_m;
    logic signed [CMP_W-1:0]  r_lhs;
    logic signed [CMP_W-1:0]  r_rhs;
    logic [DIV_W-1:0]         r_rem;
    logic [DIV_W-1:0]         r_quo;
    logic [$clog2(DIV_W)-1:0] r_cnt;
    logic                     r_charge;
    logic [BLINK_W-1:0]       r_blink;
    logic                     r_out_valid;
    logic [COLOR_W-1:0]       r_colour;
    logic [SEL_W-1:0]         r_mask;
    logic                     r_out_chg;
    logic                     r_out_low;

    logic                     bad_cfg;
    logic                     n_charge;
    logic                     below;
    logic                     low_e;
    logic [DIV_W-1:0]         level;
    logic [DIV_W-1:0]         red;
    logic [DIV_W-1:0]         green;
    logic [BLINK_W-1:0]       n_blink;
    logic                     out_free;
    logic signed [CMP_W-1:0]  num;
    logic signed [CMP_W-1:0]  den;

    cei_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cei_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    // Operand select for the shared unit
    always_comb begin
        alu_op = ALU_MUL;
        alu_a  = r_v;
        alu_b  = r_v;
        unique case (r_state)
            S_MUL_L: begin
                alu_a = cfg.low_threshold;
                alu_b = cfg.low_threshold;
            end
            S_MUL_M: begin
                alu_a = cfg.max_voltage;
                alu_b = cfg.max_voltage;
            end
            S_DIV: begin
                alu_op = ALU_DIV;
                alu_a  = VOLT_W'(r_rem);
                alu_b  = VOLT_W'(cfg.dim_divisor);
            end
            default: ;
        endcase
    end

    // Energy terms num and den; S_CMP registers them scaled as 10*num and 3*den
    always_comb begin
        num = CMP_W'(r_sq_v) - CMP_W'(r_sq_l);
        den = CMP_W'(r_sq_m) - CMP_W'(r_sq_l);
    end

    // Result assembly for the finishing cycle
    always_comb begin
        bad_cfg  = (cfg.max_voltage < cfg.high_threshold) ||
                   (cfg.high_threshold < cfg.low_threshold);
        n_charge = r_charge;
        if (r_v < cfg.low_threshold) begin
            n_charge = 1'b1;
        end
        if (r_v > cfg.high_threshold) begin
            n_charge = 1'b0;
        end
        below   = (r_lhs < r_rhs);
        level   = (cfg.dim_divisor != '0) ? r_quo : '0;
        red     = '0;
        green   = '0;
        low_e   = 1'b0;
        n_blink = r_blink;
        if (below && !n_charge) begin
            red   = level;
            low_e = 1'b1;
        end else if (n_charge) begin
            if (r_blink < BLINK_W'(BLINK_ON_TICKS)) begin
                red = level;
            end
            n_blink = (r_blink == BLINK_W'(BLINK_PERIOD - 1)) ? '0 : r_blink + 1'b1;
        end else begin
            green = level;
        end
        out_free = !r_out_valid || i_out_ready;
    end

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_charge    <= 1'b0;
            r_blink     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_v <= i_voltage_sample;
                        if (!bad_cfg) begin
                            r_state <= S_MUL_V;
                        end
                    end
                end
                S_MUL_V: begin
                    r_sq_v  <= alu_y;
                    r_state <= S_MUL_L;
                end
                S_MUL_L: begin
                    r_sq_l  <= alu_y;
                    r_state <= S_MUL_M;
                end
                S_MUL_M: begin
                    r_sq_m  <= alu_y;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_lhs   <= (num <<< 3) + (num <<< 1);
                    r_rhs   <= (den <<< 1) + den;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= alu_y[DIV_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], alu_y[DIV_W]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == $bits(r_cnt)'(DIV_W - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_charge    <= n_charge;
                        r_blink     <= n_blink;
                        r_out_valid <= 1'b1;
                        r_colour    <= {green, red, 8'h00};
                        r_mask      <= cfg.led_select & LED_MASK;
                        r_out_chg   <= n_charge;
                        r_out_low   <= low_e;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_colour_grb = r_colour;
    assign o_led_mask   = r_mask;
    assign o_charging   = r_out_chg;
    assign o_low_energy = r_out_low;

endmodule

`default_nettype wire

// ===== sv/cei_cfg.sv =====
// Configuration register file of the capacitor energy indicator.
// Depends on cei_pkg.
`default_nettype none

module cei_cfg
    import cei_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VOLT_W-1:0]    i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_voltage    <= VOLT_W'(24000);
            r_cfg.high_threshold <= VOLT_W'(20000);
            r_cfg.low_threshold  <= VOLT_W'(12000);
            r_cfg.led_select     <= SEL_W'(1);
            r_cfg.dim_divisor    <= DIV_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_VOLTAGE: r_cfg.max_voltage    <= i_cfg_wdata;
                CFG_HIGH_THRESH: r_cfg.high_threshold <= i_cfg_wdata;
                CFG_LOW_THRESH:  r_cfg.low_threshold  <= i_cfg_wdata;
                CFG_LED_SELECT:  r_cfg.led_select     <= i_cfg_wdata[SEL_W-1:0];
                CFG_DIM_DIVISOR: r_cfg.dim_divisor    <= i_cfg_wdata[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/cei_alu.sv =====
// Shared arithmetic unit: 15x15 multiply, or one restoring divide step of 255 / d.
// Depends on cei_pkg.
`default_nettype none

module cei_alu
    import cei_pkg::*;
(
    input  wire t_alu_op           i_op,
    input  wire logic [VOLT_W-1:0] i_a,
    input  wire logic [VOLT_W-1:0] i_b,
    output logic [SQ_W-1:0]        o_y
);

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    // Divide step: shift in a one (dividend is all ones), trial subtract
    always_comb begin
        trial = {i_a[DIV_W-1:0], 1'b1};
        diff  = trial - {1'b0, i_b[DIV_W-1:0]};
        ge    = (trial >= {1'b0, i_b[DIV_W-1:0]});
    end

    always_comb begin
        unique case (i_op)
            ALU_MUL: o_y = SQ_W'(i_a) * SQ_W'(i_b);
            ALU_DIV: o_y = SQ_W'({ge, (ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0])});
            default: o_y = '0;
        endcase
    end

endmodule

`default_nettype wire
